@@ hdl/ncc_pkg.sv @@
// Shared types and constants for the nearest centroid classifier.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package ncc_pkg;

  // Default sizing handed to the top-level parameters
  localparam int MaxCentroidsDefault = 16;
  localparam int FeatureCountDefault = 5;
  localparam int FeatureBitsDefault  = 16;

  // Fixed field widths
  localparam int IDX_W       = 4;
  localparam int LABEL_W     = 8;
  localparam int OUT_LABEL_W = 9;
  localparam int COUNT_W     = 5;
  localparam int DIST_W      = 35;
  localparam int SUM_W       = DIST_W + 3;   // room for five saturated terms
  localparam int IN_FIELDS   = 5;            // feature fields on the input stream

  localparam logic [DIST_W-1:0]      DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [OUT_LABEL_W-1:0] LABEL_NONE = {OUT_LABEL_W{1'b1}};

  // Result stream: label, then distance, padded to whole bytes
  localparam int OUT_FIELDS_W = OUT_LABEL_W + DIST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input kind carried on tuser
  localparam logic ACT_WRITE    = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  // Configuration port: 64-bit data, registers every 8 bytes
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_SEL_BIT = 3;
  localparam logic REG_IDX_IN_USE = 1'b0;
  localparam logic REG_IDX_REJECT = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] in_use;
    logic [DIST_W-1:0]  reject;
  } cfg_t;

  // Travels alongside each centroid through the distance pipeline
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [LABEL_W-1:0] label;
  } tag_t;

endpackage

`default_nettype wire

@@ hdl/ncc_cfg_regs.sv @@
// Configuration registers behind a simple APB-style port.
// Depends on ncc_pkg for the register layout and the cfg_t bundle.
`default_nettype none

module ncc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ncc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ncc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output ncc_pkg::cfg_t                   cfg
);

  ncc_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic          reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[ncc_pkg::CFG_SEL_BIT];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_use <= '0;
      cfg_r.reject <= ncc_pkg::DIST_MAX;
    end else if (wr_en) begin
      unique case (reg_sel)
        ncc_pkg::REG_IDX_IN_USE: cfg_r.in_use <= cfg_pwdata[ncc_pkg::COUNT_W-1:0];
        ncc_pkg::REG_IDX_REJECT: cfg_r.reject <= cfg_pwdata[ncc_pkg::DIST_W-1:0];
        default:                 cfg_r        <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ncc_pkg::REG_IDX_IN_USE: cfg_prdata = ncc_pkg::CFG_DATA_W'(cfg_r.in_use);
      ncc_pkg::REG_IDX_REJECT: cfg_prdata = ncc_pkg::CFG_DATA_W'(cfg_r.reject);
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ncc_dist_pipe.sv @@
// Three-stage squared-distance pipeline: magnitude, square, saturating sum.
// Depends on ncc_pkg for tag_t and the distance width.
`default_nettype none

module ncc_dist_pipe #(
  parameter int FEATURE_COUNT = ncc_pkg::FeatureCountDefault,
  parameter int FEATURE_BITS  = ncc_pkg::FeatureBitsDefault
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0] point,
  input  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0] cent,
  input  ncc_pkg::tag_t                              in_tag,
  output logic [ncc_pkg::DIST_W-1:0]                 sum,
  output ncc_pkg::tag_t                              sum_tag
);

  localparam int FB = FEATURE_BITS;
  localparam int PW = 2 * FEATURE_BITS;

  logic signed [FB:0]            diff    [FEATURE_COUNT];
  logic [FB-1:0]                 mag_nxt [FEATURE_COUNT];
  logic [FB-1:0]                 mag_r   [FEATURE_COUNT];
  logic [PW-1:0]                 prod_r  [FEATURE_COUNT];
  logic [ncc_pkg::DIST_W-1:0]    term    [FEATURE_COUNT];
  logic [ncc_pkg::SUM_W-1:0]     acc;
  logic [ncc_pkg::DIST_W-1:0]    sum_nxt;
  logic [ncc_pkg::DIST_W-1:0]    sum_r;
  ncc_pkg::tag_t                 tag1_r, tag2_r, tag3_r;

  // Stage 1: absolute difference per feature
  always_comb begin
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      diff[f]    = $signed({point[f][FB-1], point[f]}) - $signed({cent[f][FB-1], cent[f]});
      mag_nxt[f] = diff[f][FB] ? FB'(-diff[f]) : FB'(diff[f]);
    end
  end

  // Stage 3: saturate each square, then add and saturate the total
  always_comb begin
    acc = '0;
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      term[f] = (64'(prod_r[f]) > 64'(ncc_pkg::DIST_MAX)) ? ncc_pkg::DIST_MAX
                                                          : ncc_pkg::DIST_W'(prod_r[f]);
      acc     = acc + ncc_pkg::SUM_W'(term[f]);
    end
    sum_nxt = (acc > ncc_pkg::SUM_W'(ncc_pkg::DIST_MAX)) ? ncc_pkg::DIST_MAX
                                                         : ncc_pkg::DIST_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      mag_r[f]  <= mag_nxt[f];
      prod_r[f] <= PW'(mag_r[f]) * PW'(mag_r[f]);
    end
    sum_r <= sum_nxt;
  end

  assign sum     = sum_r;
  assign sum_tag = tag3_r;

endmodule

`default_nettype wire

@@ hdl/ncc_engine.sv @@
// Centroid table memory, scan sequencer and running minimum.
// Depends on ncc_pkg; feeds ncc_dist_pipe and takes its sums back.
`default_nettype none

module ncc_engine #(
  parameter int MAX_CENTROIDS = ncc_pkg::MaxCentroidsDefault,
  parameter int FEATURE_COUNT = ncc_pkg::FeatureCountDefault,
  parameter int FEATURE_BITS  = ncc_pkg::FeatureBitsDefault
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  ncc_pkg::cfg_t                              cfg,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_action,
  input  logic [ncc_pkg::IDX_W-1:0]                  in_index,
  input  logic [ncc_pkg::LABEL_W-1:0]                in_label,
  input  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0] in_feat,
  output logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0] point,
  output logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0] rd_cent,
  output ncc_pkg::tag_t                              rd_tag,
  input  logic [ncc_pkg::DIST_W-1:0]                 sum,
  input  ncc_pkg::tag_t                              sum_tag,
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output logic [ncc_pkg::OUT_LABEL_W-1:0]            res_label,
  output logic [ncc_pkg::DIST_W-1:0]                 res_dist
);

  localparam int AW      = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int FEAT_W  = FEATURE_COUNT * FEATURE_BITS;
  localparam int ENTRY_W = FEAT_W + ncc_pkg::LABEL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                            state_r;
  logic [ENTRY_W-1:0]                mem [MAX_CENTROIDS];
  logic [ENTRY_W-1:0]                rd_entry_r;
  logic                              rd_vld_r;
  logic                              rd_last_r;
  logic [ncc_pkg::COUNT_W-1:0]       cnt_r;
  logic [ncc_pkg::COUNT_W-1:0]       last_idx_r;
  logic [ncc_pkg::COUNT_W-1:0]       n_search;
  logic [FEAT_W-1:0]                 point_r;
  logic [ncc_pkg::DIST_W-1:0]        best_r;
  logic [ncc_pkg::OUT_LABEL_W-1:0]   label_r;
  logic                              accept;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [AW-1:0]                     rd_addr;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_action == ncc_pkg::ACT_WRITE)
                    && (32'(in_index) < 32'(MAX_CENTROIDS));
  assign wr_addr  = AW'(in_index);
  assign rd_addr  = AW'(cnt_r);

  // Clamp the searched count to the table depth
  assign n_search = (32'(cfg.in_use) > 32'(MAX_CENTROIDS)) ?
                    ncc_pkg::COUNT_W'(MAX_CENTROIDS) : cfg.in_use;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_label, in_feat};
    end
    rd_entry_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_action == ncc_pkg::ACT_CLASSIFY)) begin
            point_r    <= in_feat;
            best_r     <= cfg.reject;
            label_r    <= ncc_pkg::LABEL_NONE;
            cnt_r      <= '0;
            last_idx_r <= n_search - 1'b1;
            state_r    <= (n_search == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_r  <= 1'b1;
          rd_last_r <= (cnt_r == last_idx_r);
          cnt_r     <= cnt_r + 1'b1;
          if (cnt_r == last_idx_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sum_tag.vld && sum_tag.last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // strict compare keeps the lower index on a tie
      if (sum_tag.vld && (sum < best_r)) begin
        best_r  <= sum;
        label_r <= {1'b0, sum_tag.label};
      end
    end
  end

  assign point         = point_r;
  assign rd_cent       = rd_entry_r[FEAT_W-1:0];
  assign rd_tag.vld    = rd_vld_r;
  assign rd_tag.last   = rd_last_r;
  assign rd_tag.label  = rd_entry_r[ENTRY_W-1:FEAT_W];

  assign res_valid = (state_r == ST_DONE);
  assign res_label = label_r;
  assign res_dist  = best_r;

endmodule

`default_nettype wire

@@ hdl/nearest_centroid_classifier.sv @@
// Nearest centroid classifier: a table of up to MAX_CENTROIDS entries,
// each FEATURE_COUNT signed features and an 8-bit label, searched for the
// entry with the least squared Euclidean distance to a classify point. A
// write transaction (tuser low) loads one entry. A classify transaction
// (tuser high) reads one entry per cycle from the table memory, which has a
// single read port, and streams it through a three-stage distance pipeline;
// it searches the first n entries, n being centroids_in_use clamped to the
// table depth. Items are worked on one at a time; a finished result sits in
// the output register while the next transaction is taken. Table entries
// hold no reset value and must be written before they fall inside the
// searched range. The label is all ones, and the distance the reject value,
// when no entry qualifies.
// Depends on ncc_pkg, ncc_cfg_regs, ncc_engine and ncc_dist_pipe.
`default_nettype none

module nearest_centroid_classifier #(
  parameter int MAX_CENTROIDS = ncc_pkg::MaxCentroidsDefault,
  parameter int FEATURE_COUNT = ncc_pkg::FeatureCountDefault,
  parameter int FEATURE_BITS  = ncc_pkg::FeatureBitsDefault,
  localparam int IN_FIELDS_W  = ncc_pkg::IDX_W + ncc_pkg::LABEL_W
                                + ncc_pkg::IN_FIELDS * FEATURE_BITS,
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // entry_index, entry_label, feature_zero .. feature_four
  input  logic [IN_DATA_W-1:0]              in_tdata,
  // action
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cluster_label, best_distance_sq
  output logic [ncc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ncc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int FEAT_LSB = ncc_pkg::IDX_W + ncc_pkg::LABEL_W;

  ncc_pkg::cfg_t                                cfg;
  ncc_pkg::tag_t                                rd_tag;
  ncc_pkg::tag_t                                sum_tag;
  logic [ncc_pkg::IN_FIELDS-1:0][FEATURE_BITS-1:0] all_feat;
  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0]   in_feat;
  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0]   point;
  logic [FEATURE_COUNT-1:0][FEATURE_BITS-1:0]   rd_cent;
  logic [ncc_pkg::DIST_W-1:0]                   sum;
  logic                                         res_valid;
  logic                                         res_ready;
  logic [ncc_pkg::OUT_LABEL_W-1:0]              res_label;
  logic [ncc_pkg::DIST_W-1:0]                   res_dist;
  logic                                         out_valid_r;
  logic [ncc_pkg::OUT_FIELDS_W-1:0]             out_data_r;

  always_comb begin
    for (int f = 0; f < ncc_pkg::IN_FIELDS; f++) begin
      all_feat[f] = in_tdata[FEAT_LSB + f*FEATURE_BITS +: FEATURE_BITS];
    end
  end
  assign in_feat = all_feat[FEATURE_COUNT-1:0];

  ncc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ncc_engine #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .FEATURE_COUNT (FEATURE_COUNT),
    .FEATURE_BITS  (FEATURE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_index  (in_tdata[ncc_pkg::IDX_W-1:0]),
    .in_label  (in_tdata[ncc_pkg::IDX_W +: ncc_pkg::LABEL_W]),
    .in_feat   (in_feat),
    .point     (point),
    .rd_cent   (rd_cent),
    .rd_tag    (rd_tag),
    .sum       (sum),
    .sum_tag   (sum_tag),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_label (res_label),
    .res_dist  (res_dist)
  );

  ncc_dist_pipe #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .FEATURE_BITS  (FEATURE_BITS)
  ) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .point   (point),
    .cent    (rd_cent),
    .in_tag  (rd_tag),
    .sum     (sum),
    .sum_tag (sum_tag)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {res_dist, res_label};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ncc_pkg::OUT_DATA_W'(out_data_r);

endmodule

`default_nettype wire
